FILE: rtl/z80_next_pc_predictor_assert.svh
// assertion macros for the next-pc predictor checker
`ifndef Z80_NEXT_PC_PREDICTOR_ASSERT_SVH
`define Z80_NEXT_PC_PREDICTOR_ASSERT_SVH

// plain property checked on every clock edge out of reset
`define Z80NPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent followed in the next cycle by the consequent
`define Z80NPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/z80npp_pkg.sv
// ----------------------------------------------------------------------------
// z80npp_pkg
// types, decode tables and helpers for the z80 next-pc predictor
// ----------------------------------------------------------------------------
`default_nettype none

package z80npp_pkg;

    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 3;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 16;

    typedef enum logic [3:0] {
        ACT_STEP,
        ACT_DJNZ,
        ACT_JR,
        ACT_JRCC,
        ACT_JPNN,
        ACT_JPCC,
        ACT_JPHL,
        ACT_RET,
        ACT_RETCC,
        ACT_RST,
        ACT_ED,
        ACT_IND
    } act_t;

    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] mask;
        act_t              act;
        logic [LEN_W-1:0]  len;
    } row_t;

    // decoded action for one instruction
    typedef struct packed {
        act_t             act;
        logic [LEN_W-1:0] len;
    } dec_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [ADDR_W-1:0] stack_word;
        logic [ADDR_W-1:0] hl_value;
        logic [BYTE_W-1:0] b_reg;
        logic [BYTE_W-1:0] flags_byte;
        logic [BYTE_W-1:0] third_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] opcode_byte;
        logic [ADDR_W-1:0] pc_addr;
    } item_t;

    localparam int MAIN_N = 55;
    localparam int ED_N   = 25;
    localparam int IND_N  = 28;

    localparam row_t MAIN_TAB [MAIN_N] = '{
        '{8'h00, 8'hFF, ACT_STEP, 3'd1}, '{8'h01, 8'hCF, ACT_STEP, 3'd3},
        '{8'h02, 8'hFF, ACT_STEP, 3'd1}, '{8'h03, 8'hCF, ACT_STEP, 3'd1},
        '{8'h04, 8'hC7, ACT_STEP, 3'd1}, '{8'h05, 8'hC7, ACT_STEP, 3'd1},
        '{8'h06, 8'hC7, ACT_STEP, 3'd2}, '{8'h07, 8'hFF, ACT_STEP, 3'd1},
        '{8'h08, 8'hFF, ACT_STEP, 3'd1}, '{8'h09, 8'hCF, ACT_STEP, 3'd1},
        '{8'h0A, 8'hFF, ACT_STEP, 3'd1}, '{8'h0B, 8'hCF, ACT_STEP, 3'd1},
        '{8'h0F, 8'hFF, ACT_STEP, 3'd1}, '{8'h10, 8'hFF, ACT_DJNZ, 3'd2},
        '{8'h12, 8'hFF, ACT_STEP, 3'd1}, '{8'h17, 8'hFF, ACT_STEP, 3'd1},
        '{8'h18, 8'hFF, ACT_JR,   3'd2}, '{8'h1A, 8'hFF, ACT_STEP, 3'd1},
        '{8'h1F, 8'hFF, ACT_STEP, 3'd1}, '{8'h20, 8'hE7, ACT_JRCC, 3'd2},
        '{8'h22, 8'hFF, ACT_STEP, 3'd3}, '{8'h27, 8'hFF, ACT_STEP, 3'd1},
        '{8'h2A, 8'hFF, ACT_STEP, 3'd3}, '{8'h2F, 8'hFF, ACT_STEP, 3'd1},
        '{8'h32, 8'hFF, ACT_STEP, 3'd3}, '{8'h37, 8'hFF, ACT_STEP, 3'd1},
        '{8'h3A, 8'hFF, ACT_STEP, 3'd3}, '{8'h3F, 8'hFF, ACT_STEP, 3'd1},
        '{8'h76, 8'hFF, ACT_STEP, 3'd1}, '{8'h40, 8'hC0, ACT_STEP, 3'd1},
        '{8'h80, 8'hC0, ACT_STEP, 3'd1}, '{8'hC0, 8'hC7, ACT_RETCC, 3'd1},
        '{8'hC1, 8'hCF, ACT_STEP, 3'd1}, '{8'hC2, 8'hC7, ACT_JPCC, 3'd3},
        '{8'hC3, 8'hFF, ACT_JPNN, 3'd3}, '{8'hC4, 8'hC7, ACT_JPCC, 3'd3},
        '{8'hC5, 8'hCF, ACT_STEP, 3'd1}, '{8'hC6, 8'hC7, ACT_STEP, 3'd2},
        '{8'hC7, 8'hC7, ACT_RST,  3'd1}, '{8'hC9, 8'hFF, ACT_RET,  3'd1},
        '{8'hCB, 8'hFF, ACT_STEP, 3'd2}, '{8'hCD, 8'hFF, ACT_JPNN, 3'd3},
        '{8'hD3, 8'hFF, ACT_STEP, 3'd2}, '{8'hD9, 8'hFF, ACT_STEP, 3'd1},
        '{8'hDB, 8'hFF, ACT_STEP, 3'd2}, '{8'hDD, 8'hFF, ACT_IND,  3'd0},
        '{8'hE3, 8'hFF, ACT_STEP, 3'd1}, '{8'hE9, 8'hFF, ACT_JPHL, 3'd1},
        '{8'hEB, 8'hFF, ACT_STEP, 3'd1}, '{8'hED, 8'hFF, ACT_ED,   3'd0},
        '{8'hF3, 8'hFF, ACT_STEP, 3'd1}, '{8'hF9, 8'hFF, ACT_STEP, 3'd1},
        '{8'hFB, 8'hFF, ACT_STEP, 3'd1}, '{8'hFD, 8'hFF, ACT_IND,  3'd0},
        '{8'h00, 8'h00, ACT_STEP, 3'd1}
    };

    // lengths include the ed prefix
    localparam row_t ED_TAB [ED_N] = '{
        '{8'h70, 8'hFF, ACT_STEP, 3'd2}, '{8'h40, 8'hC7, ACT_STEP, 3'd2},
        '{8'h71, 8'hFF, ACT_STEP, 3'd2}, '{8'h41, 8'hC7, ACT_STEP, 3'd2},
        '{8'h42, 8'hCF, ACT_STEP, 3'd2}, '{8'h43, 8'hCF, ACT_STEP, 3'd4},
        '{8'h44, 8'hFF, ACT_STEP, 3'd2}, '{8'h45, 8'hFF, ACT_RET,  3'd2},
        '{8'h46, 8'hFF, ACT_STEP, 3'd2}, '{8'h47, 8'hFF, ACT_STEP, 3'd2},
        '{8'h4A, 8'hCF, ACT_STEP, 3'd2}, '{8'h4B, 8'hCF, ACT_STEP, 3'd4},
        '{8'h4D, 8'hFF, ACT_RET,  3'd2}, '{8'h4F, 8'hFF, ACT_STEP, 3'd2},
        '{8'h56, 8'hFF, ACT_STEP, 3'd2}, '{8'h57, 8'hFF, ACT_STEP, 3'd2},
        '{8'h5E, 8'hFF, ACT_STEP, 3'd2}, '{8'h5F, 8'hFF, ACT_STEP, 3'd2},
        '{8'h67, 8'hFF, ACT_STEP, 3'd2}, '{8'h6F, 8'hFF, ACT_STEP, 3'd2},
        '{8'hA0, 8'hE4, ACT_STEP, 3'd2}, '{8'hC3, 8'hFF, ACT_STEP, 3'd2},
        '{8'hC5, 8'hE7, ACT_STEP, 3'd2}, '{8'hF3, 8'hFF, ACT_STEP, 3'd2},
        '{8'h00, 8'h00, ACT_STEP, 3'd2}
    };

    // lengths exclude the dd/fd prefix
    localparam row_t IND_TAB [IND_N] = '{
        '{8'h24, 8'hF7, ACT_STEP, 3'd1}, '{8'h25, 8'hF7, ACT_STEP, 3'd1},
        '{8'h26, 8'hF7, ACT_STEP, 3'd2}, '{8'h21, 8'hFF, ACT_STEP, 3'd3},
        '{8'h22, 8'hFF, ACT_STEP, 3'd3}, '{8'h2A, 8'hFF, ACT_STEP, 3'd3},
        '{8'h23, 8'hFF, ACT_STEP, 3'd1}, '{8'h2B, 8'hFF, ACT_STEP, 3'd1},
        '{8'h29, 8'hFF, ACT_STEP, 3'd1}, '{8'h09, 8'hCF, ACT_STEP, 3'd1},
        '{8'h34, 8'hFF, ACT_STEP, 3'd2}, '{8'h35, 8'hFF, ACT_STEP, 3'd2},
        '{8'h36, 8'hFF, ACT_STEP, 3'd3}, '{8'h76, 8'hFF, ACT_STEP, 3'd1},
        '{8'h46, 8'hC7, ACT_STEP, 3'd2}, '{8'h70, 8'hF8, ACT_STEP, 3'd2},
        '{8'h64, 8'hF6, ACT_STEP, 3'd1}, '{8'h60, 8'hF0, ACT_STEP, 3'd1},
        '{8'h44, 8'hC6, ACT_STEP, 3'd1}, '{8'h86, 8'hC7, ACT_STEP, 3'd2},
        '{8'h84, 8'hC6, ACT_STEP, 3'd1}, '{8'hE1, 8'hFF, ACT_STEP, 3'd1},
        '{8'hE5, 8'hFF, ACT_STEP, 3'd1}, '{8'hCB, 8'hFF, ACT_STEP, 3'd3},
        '{8'hE3, 8'hFF, ACT_STEP, 3'd1}, '{8'hE9, 8'hFF, ACT_STEP, 3'd1},
        '{8'hF9, 8'hFF, ACT_STEP, 3'd1}, '{8'h00, 8'h00, ACT_STEP, 3'd1}
    };

    // first matching row wins, last row catches everything
    function automatic row_t find_main(input logic [BYTE_W-1:0] b);
        row_t r;
        r = MAIN_TAB[MAIN_N-1];
        for (int i = MAIN_N - 1; i >= 0; i--)
        begin
            if ((b & MAIN_TAB[i].mask) == MAIN_TAB[i].val)
            begin
                r = MAIN_TAB[i];
            end
        end
        return r;
    endfunction

    function automatic row_t find_ed(input logic [BYTE_W-1:0] b);
        row_t r;
        r = ED_TAB[ED_N-1];
        for (int i = ED_N - 1; i >= 0; i--)
        begin
            if ((b & ED_TAB[i].mask) == ED_TAB[i].val)
            begin
                r = ED_TAB[i];
            end
        end
        return r;
    endfunction

    function automatic row_t find_ind(input logic [BYTE_W-1:0] b);
        row_t r;
        r = IND_TAB[IND_N-1];
        for (int i = IND_N - 1; i >= 0; i--)
        begin
            if ((b & IND_TAB[i].mask) == IND_TAB[i].val)
            begin
                r = IND_TAB[i];
            end
        end
        return r;
    endfunction

    // condition codes nz z nc c po pe p m
    function automatic logic cond_holds(input logic [2:0] cc,
                                        input logic [BYTE_W-1:0] f);
        logic flag;
        unique case (cc[2:1])
            2'd0:    flag = f[6];
            2'd1:    flag = f[0];
            2'd2:    flag = f[2];
            default: flag = f[7];
        endcase
        return flag == cc[0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/z80_next_pc_predictor.sv
// ----------------------------------------------------------------------------
// z80_next_pc_predictor
// predicts the address of the next z80 instruction from pc, bytes and regs
// ----------------------------------------------------------------------------
// usage
//   s_* carries one query per transfer: pc, three instruction bytes, f, b,
//   hl and the word at the top of the stack, packed into s_tdata.
//   m_* returns one next_pc per query, in query order.
//   a query passes through one input register, then decode and target
//   add into the output register, which drives m_tvalid and m_tdata.
//   throughput is one query per cycle unless m_tready stalls; s_tready is
//   high while the input register is empty or the output one advances, so
//   an empty input register takes a query while a result waits for m_tready.
//   when m_tready is low both registers hold and s_tready drops once the
//   input register is also full; nothing is lost or repeated.
//   reset empties both stages; the block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module z80_next_pc_predictor
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pc_addr, opcode_byte, second_byte, third_byte, flags_byte, b_reg,
    // hl_value, stack_word
    input  wire logic [z80npp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // next_pc
    output logic [z80npp_pkg::M_DATA_W-1:0]        m_tdata
);
    import z80npp_pkg::*;

    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_pc_reg;
    logic              out_adv;
    logic              in_adv;
    dec_t              dec;
    logic [ADDR_W-1:0] next_pc;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign in_adv   = s_tvalid && s_tready;

    z80npp_decode u_decode
    (
        .opcode_byte (in_item_reg.opcode_byte),
        .second_byte (in_item_reg.second_byte),
        .dec         (dec)
    );

    z80npp_target u_target
    (
        .item    (in_item_reg),
        .dec     (dec),
        .next_pc (next_pc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            in_item_reg <= item_t'(s_tdata);
        end
        if (out_adv && in_valid_reg)
        begin
            out_pc_reg <= next_pc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pc_reg;

endmodule

`default_nettype wire

FILE: rtl/z80npp_decode.sv
// ----------------------------------------------------------------------------
// z80npp_decode
// priority table match of the opcode, with ed and dd/fd second-byte tables
// ----------------------------------------------------------------------------
`default_nettype none

module z80npp_decode
(
    input  wire logic [z80npp_pkg::BYTE_W-1:0] opcode_byte,
    input  wire logic [z80npp_pkg::BYTE_W-1:0] second_byte,
    output z80npp_pkg::dec_t                   dec
);
    import z80npp_pkg::*;

    row_t main_row;
    row_t ed_row;
    row_t ind_row;

    assign main_row = find_main(opcode_byte);
    assign ed_row   = find_ed(second_byte);
    assign ind_row  = find_ind(second_byte);

    always_comb
    begin
        dec.act = main_row.act;
        dec.len = main_row.len;
        if (main_row.act == ACT_ED)
        begin
            dec.act = (ed_row.act == ACT_RET) ? ACT_RET : ACT_STEP;
            dec.len = ed_row.len;
        end
        else if (main_row.act == ACT_IND)
        begin
            dec.act = ACT_STEP;
            dec.len = ind_row.len + LEN_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/z80npp_target.sv
// ----------------------------------------------------------------------------
// z80npp_target
// resolves the next address from the decoded action and the register values
// ----------------------------------------------------------------------------
`default_nettype none

module z80npp_target
(
    input  wire z80npp_pkg::item_t             item,
    input  wire z80npp_pkg::dec_t              dec,
    output logic [z80npp_pkg::ADDR_W-1:0]      next_pc
);
    import z80npp_pkg::*;

    logic [ADDR_W-1:0] seq_pc;
    logic [ADDR_W-1:0] pc_plus2;
    logic [ADDR_W-1:0] rel_pc;
    logic [ADDR_W-1:0] nn;
    logic [ADDR_W-1:0] rst_pc;
    logic              cc_full;
    logic              cc_jr;

    assign seq_pc   = item.pc_addr + {{(ADDR_W-LEN_W){1'b0}}, dec.len};
    assign pc_plus2 = item.pc_addr + ADDR_W'(2);
    assign rel_pc   = pc_plus2 + {{(ADDR_W-BYTE_W){item.second_byte[BYTE_W-1]}},
                                  item.second_byte};
    assign nn       = {item.third_byte, item.second_byte};
    assign rst_pc   = {{(ADDR_W-6){1'b0}}, item.opcode_byte[5:3], 3'b000};
    assign cc_full  = cond_holds(item.opcode_byte[5:3], item.flags_byte);
    assign cc_jr    = cond_holds({1'b0, item.opcode_byte[4:3]}, item.flags_byte);

    always_comb
    begin
        unique case (dec.act)
            ACT_DJNZ:  next_pc = (item.b_reg == BYTE_W'(1)) ? pc_plus2 : rel_pc;
            ACT_JR:    next_pc = rel_pc;
            ACT_JRCC:  next_pc = cc_jr ? rel_pc : pc_plus2;
            ACT_JPNN:  next_pc = nn;
            ACT_JPCC:  next_pc = cc_full ? nn : seq_pc;
            ACT_JPHL:  next_pc = item.hl_value;
            ACT_RET:   next_pc = item.stack_word;
            ACT_RETCC: next_pc = cc_full ? item.stack_word : seq_pc;
            ACT_RST:   next_pc = rst_pc;
            default:   next_pc = seq_pc;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/z80npp_checker.sv
// ----------------------------------------------------------------------------
// z80npp_checker
// port-level checks on the next-pc predictor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "z80_next_pc_predictor_assert.svh"

module z80npp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [87:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    localparam logic [7:0] OP_JP_NN = 8'hC3;

    `Z80NPP_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    `Z80NPP_ASSERT_NEXT(a_m_stable, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata moved")
    `Z80NPP_ASSERT_NEXT(a_flow, s_tvalid && s_tready ##1 m_tready, m_tvalid, "result lost")
    `Z80NPP_ASSERT_NEXT(a_jp_nn, s_tvalid && s_tready && s_tdata[23:16] == OP_JP_NN ##1 m_tready, m_tdata == {$past(s_tdata[39:32], 2), $past(s_tdata[31:24], 2)}, "jp nn target wrong")

endmodule

bind z80_next_pc_predictor z80npp_checker u_checker (.*);

`default_nettype wire
